// ===== rtl/core/wvf_pkg.sv =====
// Shared types and constants for the waypoints-to-vehicle-frame block.
// Depends on nothing; every other file in rtl/core imports it.
`default_nettype none

package wvf_pkg;

  localparam int MAX_HORIZON = 32;
  localparam int IDX_W       = $clog2(MAX_HORIZON);
  localparam int CNT_W       = $clog2(MAX_HORIZON + 1);
  localparam int FRAC_SHIFT  = 14;
  localparam int STEP_SHIFT  = 17;   // 2.0 m in Q15.16
  localparam int MIN_POINTS  = 3;
  localparam int CFG_IDX_W   = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POSE_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POSE_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COS_NEG = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_NEG = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZON = 3'd4;

  localparam logic signed [15:0] COS_RESET     = 16'sd16384;
  localparam logic [5:0]         HORIZON_RESET = 6'd10;

  typedef struct packed {
    logic signed [31:0] wp_x;
    logic signed [31:0] wp_y;
    logic               last_waypoint;
  } wvf_in_t;

  typedef struct packed {
    logic signed [31:0] ref_x;
    logic signed [31:0] ref_y;
    logic               last_point;
    logic               straight_fallback;
  } wvf_out_t;

  typedef struct packed {
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic signed [15:0] cos_neg_heading;
    logic signed [15:0] sin_neg_heading;
    logic [5:0]         horizon_len;
  } wvf_cfg_t;

  // Result of the transform pipeline, handed to the commit logic
  typedef struct packed {
    logic               valid;
    logic               last;
    logic signed [31:0] lx;
    logic signed [31:0] ly;
  } wvf_local_t;

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } wvf_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/waypoints_to_vehicle_frame.sv =====
// Top level of the waypoints-to-vehicle-frame block: config registers, commit, burst.
// Depends on wvf_pkg, wvf_xform and wvf_store.
//
// Usage:
//   wp channel (wp_valid/wp_ready/wp): one world waypoint per transaction,
//   Q15.16. Waypoints are taken one per cycle while wp_ready is high; each
//   passes the transform pipeline (subtract, multiply, shift/saturate) and
//   is then committed to the point store if it lies ahead of the vehicle
//   and the horizon is not yet full.
//   The transaction with last_waypoint set closes the list: wp_ready drops
//   until the whole burst is delivered on the pt channel
//   (pt_valid/pt_ready/pt). The points then appear one per cycle while
//   pt_ready is high, set by the single read port of the point store.
//   With fewer than three kept points the burst is a straight line at 2 m
//   steps, the effective horizon long (horizon_len, zero as one, max 32).
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data) is always ready;
//   write it only while the block is idle.
//   When pt_ready is low the output register and the one read in flight
//   hold; no point is dropped. Reset (rst, synchronous) restores the
//   register defaults and empties the list; the store needs no clearing.
`default_nettype none

module waypoints_to_vehicle_frame (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             wp_valid,
  output logic                                  wp_ready,
  input  wire wvf_pkg::wvf_in_t                 wp,
  output logic                                  pt_valid,
  input  wire logic                             pt_ready,
  output wvf_pkg::wvf_out_t                     pt,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [wvf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [31:0]                      cfg_data
);
  import wvf_pkg::*;

  wvf_cfg_t           cfg;
  wvf_local_t         loc;
  wvf_state_t         state, state_next;

  logic               take;
  logic               hold;
  logic [CNT_W-1:0]   kept_count;
  logic [CNT_W-1:0]   kept_after;
  logic [CNT_W-1:0]   horizon;
  logic [CNT_W-1:0]   n_emit;
  logic               keep;
  logic               list_end;

  logic [CNT_W-1:0]   emit_idx;
  logic [CNT_W-1:0]   emit_cnt;
  logic               emit_fb;
  logic               emitting;

  logic               rv;
  logic [IDX_W-1:0]   r_idx;
  logic               r_last;
  logic               r_fb;
  logic               issue;
  logic               advance;
  logic               done;
  logic [63:0]        rd_data;
  logic [31:0]        gen_x;

  assign cfg_ready = 1'b1;
  assign take      = wp_valid && wp_ready;
  assign wp_ready  = !hold;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pose_x          <= '0;
      cfg.pose_y          <= '0;
      cfg.cos_neg_heading <= COS_RESET;
      cfg.sin_neg_heading <= '0;
      cfg.horizon_len     <= HORIZON_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POSE_X:  cfg.pose_x          <= cfg_data;
        REG_POSE_Y:  cfg.pose_y          <= cfg_data;
        REG_COS_NEG: cfg.cos_neg_heading <= cfg_data[15:0];
        REG_SIN_NEG: cfg.sin_neg_heading <= cfg_data[15:0];
        REG_HORIZON: cfg.horizon_len     <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // Effective horizon: zero acts as one, clamp to the store depth
  always_comb begin
    if (cfg.horizon_len == '0) begin
      horizon = CNT_W'(1);
    end else if (CNT_W'(cfg.horizon_len) > CNT_W'(MAX_HORIZON)) begin
      horizon = CNT_W'(MAX_HORIZON);
    end else begin
      horizon = CNT_W'(cfg.horizon_len);
    end
  end

  wvf_xform u_xform (
    .clk (clk),
    .rst (rst),
    .take(take),
    .wp  (wp),
    .cfg (cfg),
    .res (loc)
  );

  // Commit: keep points ahead of the vehicle while the horizon has room
  always_comb begin
    keep       = loc.valid && (kept_count < horizon) && (loc.lx > 0);
    kept_after = keep ? kept_count + CNT_W'(1) : kept_count;
    n_emit     = (kept_after < horizon) ? kept_after : horizon;
    list_end   = loc.valid && loc.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count <= '0;
    end else if (list_end) begin
      kept_count <= '0;
    end else begin
      kept_count <= kept_after;
    end
  end

  // Input stays closed from the last waypoint until the burst is delivered,
  // so no store write ever overlaps a burst read.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold <= 1'b0;
    end else if (take && wp.last_waypoint) begin
      hold <= 1'b1;
    end else if (done) begin
      hold <= 1'b0;
    end
  end

  // Burst sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_COLLECT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT: if (list_end) state_next = ST_EMIT;
      ST_EMIT:    if (done)     state_next = ST_COLLECT;
      default:    state_next = ST_COLLECT;
    endcase
  end

  always_comb begin
    case (state)
      ST_EMIT: emitting = 1'b1;
      default: emitting = 1'b0;
    endcase
  end

  // Latch burst length and kind at the end of the list
  always_ff @(posedge clk) begin
    if (list_end) begin
      emit_fb  <= (n_emit < CNT_W'(MIN_POINTS));
      emit_cnt <= (n_emit < CNT_W'(MIN_POINTS)) ? horizon : n_emit;
    end
  end

  assign advance = rv && (!pt_valid || pt_ready);
  assign issue   = emitting && (emit_idx < emit_cnt) && (!rv || advance);
  assign done    = pt_valid && pt_ready && pt.last_point;

  always_ff @(posedge clk) begin
    if (rst) begin
      emit_idx <= '0;
    end else if (list_end) begin
      emit_idx <= '0;
    end else if (issue) begin
      emit_idx <= emit_idx + CNT_W'(1);
    end
  end

  wvf_store u_store (
    .clk    (clk),
    .wr_en  (keep),
    .wr_addr(kept_count[IDX_W-1:0]),
    .wr_data({loc.lx, loc.ly}),
    .rd_en  (issue),
    .rd_addr(emit_idx[IDX_W-1:0]),
    .rd_data(rd_data)
  );

  // Read stage: tag travels alongside the read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else if (issue) begin
      rv <= 1'b1;
    end else if (advance) begin
      rv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      r_idx  <= emit_idx[IDX_W-1:0];
      r_last <= (emit_idx + CNT_W'(1) == emit_cnt);
      r_fb   <= emit_fb;
    end
  end

  assign gen_x = (32'(r_idx) + 32'd1) << STEP_SHIFT;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid <= 1'b0;
    end else if (advance) begin
      pt_valid <= 1'b1;
    end else if (pt_ready) begin
      pt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pt.ref_x             <= r_fb ? gen_x : rd_data[63:32];
      pt.ref_y             <= r_fb ? 32'd0 : rd_data[31:0];
      pt.last_point        <= r_last;
      pt.straight_fallback <= r_fb;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wvf_store.sv =====
// Point store: single-port-write, single-port-read synchronous RAM of local points.
// Depends on wvf_pkg for depth and index width.
`default_nettype none

module wvf_store (
  input  wire logic                      clk,
  input  wire logic                      wr_en,
  input  wire logic [wvf_pkg::IDX_W-1:0] wr_addr,
  input  wire logic [63:0]               wr_data,
  input  wire logic                      rd_en,
  input  wire logic [wvf_pkg::IDX_W-1:0] rd_addr,
  output logic [63:0]                    rd_data
);
  import wvf_pkg::*;

  logic [63:0] mem [MAX_HORIZON];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/wvf_xform.sv =====
// Three-stage world-to-vehicle transform: subtract pose, rotate, shift and saturate.
// Depends on wvf_pkg for payload, configuration and result types.
`default_nettype none

module wvf_xform (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                take,
  input  wire wvf_pkg::wvf_in_t    wp,
  input  wire wvf_pkg::wvf_cfg_t   cfg,
  output wvf_pkg::wvf_local_t      res
);
  import wvf_pkg::*;

  logic               v1, v2, v3;
  logic               last1, last2, last3;
  logic signed [32:0] dx1, dy1;
  logic signed [48:0] p_xc, p_ys, p_xs, p_yc;
  logic signed [49:0] s_x, s_y;
  logic signed [35:0] sh_x, sh_y;
  logic signed [31:0] lx3, ly3;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v[35:31] == 5'b00000 || v[35:31] == 5'b11111) begin
      r = v[31:0];
    end else if (v[35]) begin
      r = {1'b1, 31'd0};
    end else begin
      r = {1'b0, {31{1'b1}}};
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= take;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Exact 33-bit differences
  always_ff @(posedge clk) begin
    dx1   <= 33'($signed(wp.wp_x)) - 33'($signed(cfg.pose_x));
    dy1   <= 33'($signed(wp.wp_y)) - 33'($signed(cfg.pose_y));
    last1 <= wp.last_waypoint;
  end

  always_ff @(posedge clk) begin
    p_xc  <= dx1 * $signed(cfg.cos_neg_heading);
    p_ys  <= dy1 * $signed(cfg.sin_neg_heading);
    p_xs  <= dx1 * $signed(cfg.sin_neg_heading);
    p_yc  <= dy1 * $signed(cfg.cos_neg_heading);
    last2 <= last1;
  end

  always_comb begin
    s_x  = 50'(p_xc) - 50'(p_ys);
    s_y  = 50'(p_xs) + 50'(p_yc);
    sh_x = 36'(s_x >>> FRAC_SHIFT);
    sh_y = 36'(s_y >>> FRAC_SHIFT);
  end

  always_ff @(posedge clk) begin
    lx3   <= sat32(sh_x);
    ly3   <= sat32(sh_y);
    last3 <= last2;
  end

  assign res.valid = v3;
  assign res.last  = last3;
  assign res.lx    = lx3;
  assign res.ly    = ly3;

endmodule

`default_nettype wire

// ===== rtl/core/wvf_checker.sv =====
// Port-level checker for waypoints_to_vehicle_frame, attached with bind.
// Depends on wvf_pkg for the payload types.
`default_nettype none

module wvf_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 wp_valid,
  input wire logic                 wp_ready,
  input wire wvf_pkg::wvf_in_t     wp,
  input wire logic                 pt_valid,
  input wire logic                 pt_ready,
  input wire wvf_pkg::wvf_out_t    pt
);
  import wvf_pkg::*;

  // A stalled point holds its payload
  a_pt_hold: assert property (@(posedge clk) disable iff (rst)
    pt_valid && !pt_ready |=> pt_valid && $stable(pt))
    else $error("pt changed while stalled");

  // Input closes after the last waypoint of a list
  a_close: assert property (@(posedge clk) disable iff (rst)
    wp_valid && wp_ready && wp.last_waypoint |=> !wp_ready)
    else $error("wp_ready high after last waypoint");

  // No burst point while waypoints are being taken
  a_excl: assert property (@(posedge clk) disable iff (rst)
    pt_valid |-> !wp_ready)
    else $error("pt_valid while wp_ready");

  // Input reopens right after the final point
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    pt_valid && pt_ready && pt.last_point |=> wp_ready && !pt_valid)
    else $error("input not reopened after burst");

  // Straight reference runs along the x axis
  a_fb_y: assert property (@(posedge clk) disable iff (rst)
    pt_valid && pt.straight_fallback |-> pt.ref_y == 32'sd0)
    else $error("fallback point off axis");

endmodule

bind waypoints_to_vehicle_frame wvf_checker u_wvf_checker (
  .clk     (clk),
  .rst     (rst),
  .wp_valid(wp_valid),
  .wp_ready(wp_ready),
  .wp      (wp),
  .pt_valid(pt_valid),
  .pt_ready(pt_ready),
  .pt      (pt)
);

`default_nettype wire
